@@ design/arpc_pkg.sv @@
`default_nettype none

package arpc_pkg;

  localparam int TABLE_DEPTH = 128;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam int CMD_W    = 1;
  localparam int MAC_W    = 48;
  localparam int IP_W     = 32;
  localparam int KEY_W    = 8;
  localparam int PREFIX_W = 16;
  localparam int STATUS_W = 3;
  localparam int ENTRY_W  = KEY_W + MAC_W;

  localparam logic [CMD_W-1:0] CMD_LEARN  = 1'b0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 1'b1;

  localparam logic [STATUS_W-1:0] ST_LEARNED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_CACHED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OUTSIDE  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_HIT      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MISS     = 3'd4;

  localparam logic [PREFIX_W-1:0] SUBNET_RESET = 16'hC0A8;
  localparam logic [MAC_W-1:0]    MAC_BCAST    = {MAC_W{1'b1}};

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } arpc_state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } arpc_ctrl_t;

  typedef struct packed {
    logic outside;
    logic scan_last;
    logic out_busy;
  } arpc_stat_t;

endpackage

`default_nettype wire

@@ design/arpc_if.sv @@
`default_nettype none

interface arpc_req_if;
  import arpc_pkg::*;

  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [MAC_W-1:0] mac_addr;
  logic [IP_W-1:0]  ip_addr;

  modport source (output valid, output cmd, output mac_addr, output ip_addr, input ready);
  modport sink   (input valid, input cmd, input mac_addr, input ip_addr, output ready);
endinterface

interface arpc_rsp_if;
  import arpc_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [MAC_W-1:0]    found_mac;

  modport source (output valid, output status, output found_mac, input ready);
  modport sink   (input valid, input status, input found_mac, output ready);
endinterface

`default_nettype wire

@@ design/arpc_ram.sv @@
`default_nettype none

module arpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ design/arpc_ctrl.sv @@
`default_nettype none

module arpc_ctrl
  import arpc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire arpc_stat_t stat,
  output arpc_ctrl_t      ctrl
);

  arpc_state_t state;
  arpc_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = stat.outside ? S_FINISH : S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!stat.out_busy) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    ctrl.load   = 1'b0;
    ctrl.scan   = 1'b0;
    ctrl.finish = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready  = 1'b1;
        ctrl.load = in_valid;
      end
      S_SCAN: begin
        ctrl.scan = 1'b1;
      end
      S_DRAIN: begin
      end
      S_FINISH: begin
        ctrl.finish = !stat.out_busy;
      end
      default: begin
      end
    endcase
  end

  a_drain_to_finish: assert property (@(posedge clk) disable iff (rst)
    state == S_DRAIN |=> state == S_FINISH)
    else $error("drain did not lead to finish");

  a_outside_skips_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid && stat.outside) |=> state == S_FINISH)
    else $error("outside-subnet item entered scan");

endmodule

`default_nettype wire

@@ design/arpc_dp.sv @@
`default_nettype none

module arpc_dp
  import arpc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_wr_en,
  input  wire logic [PREFIX_W-1:0] cfg_wr_data,
  input  wire logic [CMD_W-1:0]    in_cmd,
  input  wire logic [MAC_W-1:0]    in_mac,
  input  wire logic [IP_W-1:0]     in_ip,
  input  wire arpc_ctrl_t          ctrl,
  output arpc_stat_t               stat,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [STATUS_W-1:0]      out_status,
  output logic [MAC_W-1:0]         out_mac
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  logic [PREFIX_W-1:0]    subnet_prefix;
  logic [TABLE_DEPTH-1:0] valid;
  logic [IDX_W-1:0]       ptr;
  logic [IDX_W-1:0]       cnt;
  logic                   chk;
  logic                   valid_rd;
  logic                   hit;
  logic [MAC_W-1:0]       found;
  logic [CMD_W-1:0]       cmd_q;
  logic [MAC_W-1:0]       mac_q;
  logic [KEY_W-1:0]       key_q;
  logic                   outside_q;
  logic [ENTRY_W-1:0]     rd_entry;
  logic                   learn_new;
  logic                   outside_in;
  logic [STATUS_W-1:0]    status_next;
  logic [MAC_W-1:0]       mac_next;

  assign outside_in = (in_cmd == CMD_LEARN) && (in_ip[IP_W-1:IP_W-PREFIX_W] != subnet_prefix);
  assign learn_new  = ctrl.finish && (cmd_q == CMD_LEARN) && !outside_q && !hit;

  assign stat.outside   = outside_in;
  assign stat.scan_last = (cnt == LAST_IDX);
  assign stat.out_busy  = out_valid && !out_ready;

  arpc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (learn_new),
    .waddr (ptr),
    .wdata ({key_q, mac_q}),
    .raddr (cnt),
    .rdata (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      subnet_prefix <= SUBNET_RESET;
    end else if (cfg_wr_en) begin
      subnet_prefix <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      ptr   <= '0;
    end else if (learn_new) begin
      valid[ptr] <= 1'b1;
      ptr        <= (ptr == LAST_IDX) ? '0 : ptr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chk <= 1'b0;
    end else begin
      chk <= ctrl.scan;
    end
  end

  always_ff @(posedge clk) begin
    valid_rd <= valid[cnt];
    if (ctrl.load) begin
      cmd_q     <= in_cmd;
      mac_q     <= in_mac;
      key_q     <= in_ip[KEY_W-1:0];
      outside_q <= outside_in;
      cnt       <= '0;
      hit       <= 1'b0;
      found     <= MAC_BCAST;
    end else begin
      if (ctrl.scan) begin
        cnt <= cnt + 1'b1;
      end
      if (chk && valid_rd && (rd_entry[ENTRY_W-1:MAC_W] == key_q)) begin
        hit   <= 1'b1;
        found <= rd_entry[MAC_W-1:0];
      end
    end
  end

  always_comb begin
    if (cmd_q == CMD_LEARN) begin
      mac_next    = '0;
      status_next = outside_q ? ST_OUTSIDE : (hit ? ST_CACHED : ST_LEARNED);
    end else begin
      mac_next    = found;
      status_next = hit ? ST_HIT : ST_MISS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      out_status <= status_next;
      out_mac    <= mac_next;
    end
  end

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    ptr <= LAST_IDX)
    else $error("insert pointer out of range");

  a_finish_shows_item: assert property (@(posedge clk) disable iff (rst)
    ctrl.finish |=> out_valid)
    else $error("finished item not presented");

  a_learn_marks_valid: assert property (@(posedge clk) disable iff (rst)
    learn_new |=> valid[$past(ptr)])
    else $error("learned entry not marked valid");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_status == ST_LEARNED || out_status == ST_CACHED ||
                   out_status == ST_OUTSIDE || out_status == ST_HIT ||
                   out_status == ST_MISS))
    else $error("undefined status code");

endmodule

`default_nettype wire

@@ design/arp_cache_learn_lookup.sv @@
// ARP cache with learn and lookup items. Each item is handled alone. A learn
// item whose top IP octets differ from subnet_prefix skips the scan and goes
// from acceptance straight to the finish state, which presents its result
// and frees the input. Every other item scans the 128-entry table through one
// read port of the entry RAM, one entry per cycle, then passes the drain and
// finish states. A finished item waits in the output register, so a new item
// may be accepted while the previous one is still to be taken. The new item
// holds in its last cycle until that result is taken. Learned pairs replace
// entries round-robin; a lookup miss returns all ones.
`default_nettype none

module arp_cache_learn_lookup
  import arpc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_wr_en,
  input  wire logic [PREFIX_W-1:0] cfg_wr_data,
  arpc_req_if.sink                 req,
  arpc_rsp_if.source               rsp
);

  arpc_ctrl_t ctrl;
  arpc_stat_t stat;

  arpc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  arpc_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_cmd      (req.cmd),
    .in_mac      (req.mac_addr),
    .in_ip       (req.ip_addr),
    .ctrl        (ctrl),
    .stat        (stat),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .out_status  (rsp.status),
    .out_mac     (rsp.found_mac)
  );

endmodule

`default_nettype wire
